### src/b64e_pkg.sv
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR         = 8'd61;
	localparam logic [7:0] NEWLINE_CHAR     = 8'd10;
	localparam logic [7:0] LINE_CHARS_RESET = 8'd64;
	localparam logic [7:0] MIN_LINE_CHARS   = 8'd4;

	// Up to four characters for one input byte, before any newlines.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} b64e_entry_t;

	typedef enum logic [1:0] {
		ST_CHAR,
		ST_WRAP,
		ST_CLOSE
	} b64e_state_t;

	function automatic logic [7:0] enc_sextet(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'd71 + {2'b00, v};
		end else if (v < 6'd62) begin
			r = 8'd48 + ({2'b00, v} - 8'd52);
		end else if (v == 6'd62) begin
			r = 8'd43;
		end else begin
			r = 8'd47;
		end
		return r;
	endfunction

endpackage

### src/b64e_front.sv
module b64e_front
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	input  logic        q_full,
	output logic        push,
	output b64e_entry_t push_entry
);

	logic [1:0] phase_q;
	logic [3:0] leftover_q;
	logic [1:0] phase_d;
	logic [3:0] leftover_d;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_entry.chars    = '0;
		push_entry.last_idx = 2'd0;
		push_entry.fin      = final_byte;
		phase_d             = 2'd0;
		leftover_d          = 4'd0;
		unique case (phase_q) inside
			2'd0, 2'd3: begin
				push_entry.chars[0] = enc_sextet(data_byte[7:2]);
				phase_d             = 2'd1;
				leftover_d          = {2'b00, data_byte[1:0]};
				if (final_byte) begin
					push_entry.chars[1] = enc_sextet({data_byte[1:0], 4'b0000});
					push_entry.chars[2] = PAD_CHAR;
					push_entry.chars[3] = PAD_CHAR;
					push_entry.last_idx = 2'd3;
				end
			end
			2'd1: begin
				push_entry.chars[0] = enc_sextet({leftover_q[1:0], data_byte[7:4]});
				phase_d             = 2'd2;
				leftover_d          = data_byte[3:0];
				if (final_byte) begin
					push_entry.chars[1] = enc_sextet({data_byte[3:0], 2'b00});
					push_entry.chars[2] = PAD_CHAR;
					push_entry.last_idx = 2'd2;
				end
			end
			default: begin
				push_entry.chars[0] = enc_sextet({leftover_q, data_byte[7:6]});
				push_entry.chars[1] = enc_sextet(data_byte[5:0]);
				push_entry.last_idx = 2'd1;
			end
		endcase
		// The final byte always leaves the group closed.
		if (final_byte) begin
			phase_d    = 2'd0;
			leftover_d = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 2'd0;
			leftover_q <= 4'd0;
		end else if (push) begin
			phase_q    <= phase_d;
			leftover_q <= leftover_d;
		end
	end

endmodule

### src/b64e_queue.sv
module b64e_queue
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  b64e_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        head_valid,
	output b64e_entry_t head_entry
);

	b64e_entry_t entries_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/b64e_back.sv
module b64e_back
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  line_chars,
	input  logic        head_valid,
	input  b64e_entry_t head_entry,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last_char
);

	b64e_state_t state_q;
	b64e_state_t state_d;
	logic [1:0]  idx_q;
	logic [7:0]  col_q;
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic        last_char_q;

	logic        load;
	logic        emit;
	logic [7:0]  emit_char;
	logic        emit_last;
	logic [7:0]  lim;
	logic [8:0]  col_inc;
	logic        wrap;
	logic        at_last;

	assign load    = !out_valid_q || out_ready;
	assign emit    = load && head_valid;
	// Lengths 1 to 3 are raised to 4 so one byte never yields more than six results.
	assign lim     = (line_chars != 8'd0 && line_chars < MIN_LINE_CHARS) ?
			MIN_LINE_CHARS : line_chars;
	assign col_inc = {1'b0, col_q} + 9'd1;
	assign wrap    = (lim != 8'd0) && (col_inc >= {1'b0, lim});
	assign at_last = (idx_q == head_entry.last_idx);

	// Next state.
	always_comb begin
		state_d = state_q;
		if (emit) begin
			unique case (state_q)
				ST_CHAR: begin
					if (wrap) begin
						state_d = ST_WRAP;
					end else if (at_last && head_entry.fin) begin
						state_d = ST_CLOSE;
					end
				end
				ST_WRAP:  state_d = ST_CHAR;
				ST_CLOSE: state_d = ST_CHAR;
				default:  state_d = ST_CHAR;
			endcase
		end
	end

	// Outputs of the sequencer.
	always_comb begin
		emit_char = head_entry.chars[idx_q];
		emit_last = 1'b0;
		unique case (state_q)
			ST_CHAR: begin
				emit_char = head_entry.chars[idx_q];
				emit_last = at_last && !wrap && !head_entry.fin;
			end
			ST_WRAP: begin
				emit_char = NEWLINE_CHAR;
				emit_last = at_last;
			end
			ST_CLOSE: begin
				emit_char = NEWLINE_CHAR;
				emit_last = 1'b1;
			end
			default: begin
				emit_char = NEWLINE_CHAR;
				emit_last = 1'b0;
			end
		endcase
		pop = emit && emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CHAR;
			idx_q       <= 2'd0;
			col_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (state_q == ST_CHAR && lim != 8'd0) begin
					col_q <= wrap ? 8'd0 : col_inc[7:0];
				end
				if (pop) begin
					idx_q <= 2'd0;
					if (head_entry.fin) begin
						col_q <= 8'd0;
					end
				end else if ((state_q == ST_CHAR && !wrap && !at_last) ||
						state_q == ST_WRAP) begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q  <= emit_char;
			last_char_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_char_q;

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop without a queued entry");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head_entry.last_idx))
		else $error("character index past the end of the entry");

	a_close_on_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |-> (head_valid && head_entry.fin && at_last))
		else $error("closing newline pending without a final entry");

	a_wrap_clears_col: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRAP) |-> (col_q == 8'd0))
		else $error("line column not cleared on wrap");

endmodule

### src/base64_stream_encoder.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    data_byte, final_byte
// output    out_valid / out_ready  out_char, last_char
// config    cfg_we                 cfg_wdata (line_chars)
//
// The front encodes a byte in the cycle it is taken and queues its characters.
// The back sends one result per cycle while out_ready allows and an entry waits: a byte
// yields one to six results, and three bytes of a steady stream give four characters plus newlines.
// The output register is the limit; the two-entry queue lets input run ahead.
// Reset clears the group phase, line column and queue, and sets line_chars to 64.
// A stalled output holds its request; input keeps flowing until the queue fills.
module base64_stream_encoder
	import b64e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_char,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic [7:0]  line_chars_q;
	logic        q_full;
	logic        push;
	b64e_entry_t push_entry;
	logic        pop;
	logic        head_valid;
	b64e_entry_t head_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_chars_q <= LINE_CHARS_RESET;
		end else if (cfg_we) begin
			line_chars_q <= cfg_wdata;
		end
	end

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_chars (line_chars_q),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_char  (last_char)
	);

endmodule
